/* rtl/pnct_pkg.sv */
// ----------------------------------------------------------------------------
// pnct_pkg
// Shared types and constants for the PN-counter origin table.
// ----------------------------------------------------------------------------
`default_nettype none

package pnct_pkg;

    // Table geometry
    localparam int MAX_ORIGINS = 16;
    localparam int IDX_W       = (MAX_ORIGINS > 1) ? $clog2(MAX_ORIGINS) : 1;
    localparam int CNT_W       = $clog2(MAX_ORIGINS + 1);

    // Field widths
    localparam int ID_W  = 32;
    localparam int TOT_W = 64;

    // Item kinds
    localparam logic KIND_INC   = 1'b0;
    localparam logic KIND_MERGE = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [ID_W-1:0]  t_id;
    typedef logic [TOT_W-1:0] t_tot;

    // One table entry's totals as held in the RAM
    typedef struct packed {
        t_tot pos;
        t_tot neg;
    } t_totals;

    // Lookup result from the origin CAM
    typedef struct packed {
        logic hit;
        t_idx hit_idx;
        logic full;
        t_idx alloc_idx;
    } t_cam_status;

endpackage

`default_nettype wire

/* rtl/pnct_if.sv */
// ----------------------------------------------------------------------------
// pnct_if
// Valid/ready channels for input items and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnct_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [pnct_pkg::ID_W-1:0]     src_id;
    logic signed [pnct_pkg::TOT_W-1:0] delta;
    logic [pnct_pkg::TOT_W-1:0]    remote_pos;
    logic [pnct_pkg::TOT_W-1:0]    remote_neg;

    modport source (output valid, kind, src_id, delta, remote_pos, remote_neg,
                    input ready);
    modport sink   (input valid, kind, src_id, delta, remote_pos, remote_neg,
                    output ready);
endinterface

interface pnct_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [pnct_pkg::TOT_W-1:0] total;
    logic                              changed;
    logic                              table_full;

    modport source (output valid, total, changed, table_full, input ready);
    modport sink   (input valid, total, changed, table_full, output ready);
endinterface

`default_nettype wire

/* rtl/pn_counter_origin_table_core.sv */
// One item in flight: lookup and RAM read, write-back, output. A dropped
//   origin skips the write-back, and a stalled result word holds the next
//   item off.
// Reset (synchronous, active low): empty table, zero running total, no
//   result pending. The totals RAM is not reset; new entries start at zero.
// ----------------------------------------------------------------------------
// pn_counter_origin_table_core
// PN-counter table keyed by origin, with increment and merge items.
// ----------------------------------------------------------------------------
`default_nettype none

module pn_counter_origin_table_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    pnct_in_if.sink     i_in,
    pnct_out_if.source  o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_MOD,
        S_DONE
    } t_state;

    t_state               r_state;

    // Captured input word
    logic                 r_kind;
    pnct_pkg::t_id        r_id;
    pnct_pkg::t_tot       r_delta;
    pnct_pkg::t_tot       r_rpos;
    pnct_pkg::t_tot       r_rneg;

    // Per-item working state
    pnct_pkg::t_idx       r_slot;
    logic                 r_new;
    pnct_pkg::t_tot       r_dpos;
    pnct_pkg::t_tot       r_dneg;
    logic                 r_changed;
    logic                 r_full;
    pnct_pkg::t_tot       r_running;

    // Output register
    logic                 r_out_valid;
    pnct_pkg::t_tot       r_out_total;
    logic                 r_out_changed;
    logic                 r_out_full;

    pnct_pkg::t_cam_status cam_status;
    logic                  cam_alloc;
    pnct_pkg::t_totals     rd_data;
    pnct_pkg::t_totals     old_totals;
    pnct_pkg::t_totals     new_totals;
    logic                  upd_changed;
    logic                  in_take;
    logic                  out_free;
    pnct_pkg::t_tot        n_running;

    assign in_take  = i_in.valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_out.ready;

    // Allocate when the origin misses and there is room
    assign cam_alloc = (r_state == S_LOOK) && !cam_status.hit && !cam_status.full;

    pnct_id_cam u_cam (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lookup_id (r_id),
        .i_alloc     (cam_alloc),
        .o_status    (cam_status)
    );

    // Read in LOOK, data in MOD; write-back in MOD. One item in flight, so
    // a read never meets a pending write to the same entry.
    pnct_totals_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (r_state == S_LOOK),
        .i_rd_addr (cam_status.hit_idx),
        .o_rd_data (rd_data),
        .i_wr_en   (r_state == S_MOD),
        .i_wr_addr (r_slot),
        .i_wr_data (new_totals)
    );

    // Fresh entries start at zero
    assign old_totals = r_new ? '0 : rd_data;

    pnct_update u_upd (
        .i_kind       (r_kind),
        .i_delta      (r_delta),
        .i_remote_pos (r_rpos),
        .i_remote_neg (r_rneg),
        .i_old        (old_totals),
        .o_new        (new_totals),
        .o_changed    (upd_changed)
    );

    assign n_running = r_running + r_dpos - r_dneg;

    // Input word capture
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind  <= i_in.kind;
            r_id    <= i_in.src_id;
            r_delta <= pnct_pkg::t_tot'(i_in.delta);
            r_rpos  <= i_in.remote_pos;
            r_rneg  <= i_in.remote_neg;
        end
    end

    // Sequencer, running total and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_running   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Output word valid: load in S_DONE, clear once taken
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_changed <= 1'b0;
                    r_dpos    <= '0;
                    r_dneg    <= '0;
                    if (cam_status.hit) begin
                        r_slot  <= cam_status.hit_idx;
                        r_new   <= 1'b0;
                        r_full  <= 1'b0;
                        r_state <= S_MOD;
                    end else if (cam_status.full) begin
                        // dropped: state unchanged, total repeats
                        r_full  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_slot  <= cam_status.alloc_idx;
                        r_new   <= 1'b1;
                        r_full  <= 1'b0;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_dpos    <= new_totals.pos - old_totals.pos;
                    r_dneg    <= new_totals.neg - old_totals.neg;
                    r_changed <= upd_changed;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_running     <= n_running;
                        r_out_total   <= n_running;
                        r_out_changed <= r_changed;
                        r_out_full    <= r_full;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.total      = $signed(r_out_total);
    assign o_out.changed    = r_out_changed;
    assign o_out.table_full = r_out_full;

endmodule

`default_nettype wire

/* rtl/pnct_id_cam.sv */
// ----------------------------------------------------------------------------
// pnct_id_cam
// Origin id store with parallel match and append-only allocation.
// ----------------------------------------------------------------------------
`default_nettype none

module pnct_id_cam (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire pnct_pkg::t_id    i_lookup_id,
    input  wire                   i_alloc,
    output pnct_pkg::t_cam_status o_status
);

    pnct_pkg::t_id  r_ids [pnct_pkg::MAX_ORIGINS];
    pnct_pkg::t_cnt r_count;

    logic            hit;
    pnct_pkg::t_idx  hit_idx;

    // Match against live entries; ids are unique so at most one hits
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < pnct_pkg::MAX_ORIGINS; i++) begin
            if ((pnct_pkg::CNT_W'(i) < r_count) && (r_ids[i] == i_lookup_id)) begin
                hit     = 1'b1;
                hit_idx = hit_idx | pnct_pkg::IDX_W'(i);
            end
        end
    end

    assign o_status.hit       = hit;
    assign o_status.hit_idx   = hit_idx;
    assign o_status.full      = (r_count == pnct_pkg::CNT_W'(pnct_pkg::MAX_ORIGINS));
    assign o_status.alloc_idx = r_count[pnct_pkg::IDX_W-1:0];

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_alloc) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Id store, written on allocation only
    always_ff @(posedge i_clk) begin
        if (i_alloc) begin
            r_ids[r_count[pnct_pkg::IDX_W-1:0]] <= i_lookup_id;
        end
    end

endmodule

`default_nettype wire

/* rtl/pnct_totals_ram.sv */
// ----------------------------------------------------------------------------
// pnct_totals_ram
// One-read one-write synchronous RAM for per-origin pos/neg totals.
// ----------------------------------------------------------------------------
`default_nettype none

module pnct_totals_ram (
    input  wire                     i_clk,
    input  wire                     i_rd_en,
    input  wire pnct_pkg::t_idx     i_rd_addr,
    output pnct_pkg::t_totals       o_rd_data,
    input  wire                     i_wr_en,
    input  wire pnct_pkg::t_idx     i_wr_addr,
    input  wire pnct_pkg::t_totals  i_wr_data
);

    pnct_pkg::t_totals r_mem [pnct_pkg::MAX_ORIGINS];
    pnct_pkg::t_totals r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/pnct_update.sv */
// ----------------------------------------------------------------------------
// pnct_update
// New totals of one entry for an increment or a merge.
// ----------------------------------------------------------------------------
`default_nettype none

module pnct_update (
    input  wire                    i_kind,
    input  wire pnct_pkg::t_tot    i_delta,
    input  wire pnct_pkg::t_tot    i_remote_pos,
    input  wire pnct_pkg::t_tot    i_remote_neg,
    input  wire pnct_pkg::t_totals i_old,
    output pnct_pkg::t_totals      o_new,
    output logic                   o_changed
);

    logic pos_up;
    logic neg_up;

    assign pos_up = (i_remote_pos > i_old.pos);
    assign neg_up = (i_remote_neg > i_old.neg);

    always_comb begin
        o_new     = i_old;
        o_changed = 1'b0;
        unique case (i_kind)
            pnct_pkg::KIND_INC: begin
                // negative delta adds its magnitude to neg; -2^63 adds 2^63
                if (!i_delta[pnct_pkg::TOT_W-1]) begin
                    o_new.pos = i_old.pos + i_delta;
                end else begin
                    o_new.neg = i_old.neg - i_delta;
                end
            end
            pnct_pkg::KIND_MERGE: begin
                if (pos_up) begin
                    o_new.pos = i_remote_pos;
                end
                if (neg_up) begin
                    o_new.neg = i_remote_neg;
                end
                o_changed = pos_up | neg_up;
            end
            default: begin
                o_new = i_old;
            end
        endcase
    end

endmodule

`default_nettype wire
